>>> design/rc5edt_pkg.sv
`timescale 1ns / 1ps

package rc5edt_pkg;

	localparam int FRAME_BITS = 13;
	localparam int TIME_W     = 16;
	localparam int SPAN_W     = TIME_W + 1;
	localparam int SHIFT_W    = 16;
	localparam int TOTAL_W    = $clog2(FRAME_BITS + 1);
	localparam int BYTE_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// input kinds carried in tuser
	localparam logic OP_EDGE = 1'b0;
	localparam logic OP_WRAP = 1'b1;

	// result status carried in tuser
	localparam logic [1:0] ST_NONE     = 2'd0;
	localparam logic [1:0] ST_COMPLETE = 2'd1;
	localparam logic [1:0] ST_FAULT    = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_LOW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_HIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_LOW   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_HIGH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DEVICE     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SUB_DEVICE = 3'd6;

	localparam logic [TIME_W-1:0] GAP_LIMIT_RST  = 16'd1850;
	localparam logic [TIME_W-1:0] SHORT_LOW_RST  = 16'd810;
	localparam logic [TIME_W-1:0] SHORT_HIGH_RST = 16'd975;
	localparam logic [TIME_W-1:0] LONG_LOW_RST   = 16'd1640;
	localparam logic [TIME_W-1:0] LONG_HIGH_RST  = 16'd1850;
	localparam logic [BYTE_W-1:0] DEVICE_RST     = 8'd128;
	localparam logic [BYTE_W-1:0] SUB_DEVICE_RST = 8'd0;

	localparam logic [1:0] WRAP_MAX = 2'd3;

	// result word, lowest field in the lowest bits
	typedef struct packed {
		logic                  pad;
		logic                  next_edge_rising;
		logic [BYTE_W-1:0]     tx_check;
		logic [BYTE_W-1:0]     tx_command;
		logic                  known_key;
		logic [FRAME_BITS-1:0] code_word;
	} result_t;

	typedef struct packed {
		logic              known;
		logic [BYTE_W-1:0] command;
	} xlat_t;

	// key translation to the target remote's command set
	function automatic xlat_t translate(input logic [BYTE_W-1:0] key);
		xlat_t r;
		r.known = 1'b1;
		unique case (key)
			8'h10:   r.command = 8'h20;
			8'h11:   r.command = 8'h21;
			8'h20:   r.command = 8'h34;
			8'h21:   r.command = 8'h35;
			8'h0d:   r.command = 8'h32;
			8'h0c:   r.command = 8'h3d;
			default: begin
				r.known   = 1'b0;
				r.command = '0;
			end
		endcase
		return r;
	endfunction

endpackage

>>> design/rc5_edge_decoder_translator.sv
`timescale 1ns / 1ps

// RC5 edge decoder and command translator. Feed it capture words from an
// infrared receiver: tuser 0 with the 16-bit free-running timer value latched
// at the edge, or tuser 1 for a timer wrap tick. Every input word produces
// exactly one result word. The interval since the previous edge is
// classified as a half period (short_low < t < short_high) or a full period
// (long_low < t <= long_high); an interval above gap_limit, or two or more
// wraps between edges, silently restarts the frame and returns the capture
// polarity to falling. Any other interval reports a timing fault. After 13
// Manchester bits the frame completes: the word is reported, its low byte is
// mapped through a six-entry key table, and the check byte device ^
// sub-device ^ command is given (all zero for an unknown key).
// next_edge_rising tells the capture logic which edge to arm next. The
// interval subtract, the bound compares and the shift update all settle
// between the accept edge and the result register, so a word is accepted
// every cycle unless the result register is held full by m_axis_tready
// low. Configuration writes are accepted every cycle and should be issued
// only while no word is in flight.
module rc5_edge_decoder_translator
	import rc5edt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// capture stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [TIME_W-1:0]     s_axis_tdata,  // [15:0] capture_time
	input  logic                  s_axis_tuser,  // [0] opcode
	// result stream
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [12:0] code_word, [13] known_key, [21:14] tx_command,
	// [29:22] tx_check, [30] next_edge_rising, [31] zero
	output logic [31:0]           m_axis_tdata,
	output logic [1:0]            m_axis_tuser   // [1:0] status
);

	// configuration registers
	logic [TIME_W-1:0] gap_limit_q, short_low_q, short_high_q, long_low_q, long_high_q;
	logic [BYTE_W-1:0] device_q, sub_device_q;

	// decoder state
	logic [TIME_W-1:0]  last_time_q;
	logic [1:0]         wrap_q;
	logic               parity_q;
	logic               level_q;
	logic [SHIFT_W-1:0] shift_q;
	logic [TOTAL_W-1:0] total_q;
	logic               rising_q;

	// next state
	logic [TIME_W-1:0]  last_time_d;
	logic [1:0]         wrap_d;
	logic               parity_d;
	logic               level_d;
	logic [SHIFT_W-1:0] shift_d;
	logic [TOTAL_W-1:0] total_d;
	logic               rising_d;

	// result register
	logic       out_valid_q;
	result_t    out_data_q;
	logic [1:0] out_status_q;
	result_t    res_d;
	logic [1:0] status_d;

	logic              s_accept;
	logic [SPAN_W-1:0] elapsed;
	logic              gap_hit, short_hit, long_hit;
	xlat_t             xlat;

	assign cfg_ready     = 1'b1;
	// the result register frees up in the same cycle it is taken
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_limit_q  <= GAP_LIMIT_RST;
			short_low_q  <= SHORT_LOW_RST;
			short_high_q <= SHORT_HIGH_RST;
			long_low_q   <= LONG_LOW_RST;
			long_high_q  <= LONG_HIGH_RST;
			device_q     <= DEVICE_RST;
			sub_device_q <= SUB_DEVICE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GAP_LIMIT:  gap_limit_q  <= cfg_data;
				REG_SHORT_LOW:  short_low_q  <= cfg_data;
				REG_SHORT_HIGH: short_high_q <= cfg_data;
				REG_LONG_LOW:   long_low_q   <= cfg_data;
				REG_LONG_HIGH:  long_high_q  <= cfg_data;
				REG_DEVICE:     device_q     <= cfg_data[BYTE_W-1:0];
				REG_SUB_DEVICE: sub_device_q <= cfg_data[BYTE_W-1:0];
				default: ;  // drop writes past the register list
			endcase
		end
	end

	// Interval since the previous edge. One wrap adds a full timer period,
	// which needs the extra bit; with no wrap the plain modular difference.
	always_comb begin
		if (wrap_q == 2'd0)
			elapsed = {1'b0, s_axis_tdata - last_time_q};
		else
			elapsed = {1'b1, {TIME_W{1'b0}}} - {1'b0, last_time_q} + {1'b0, s_axis_tdata};
	end

	assign gap_hit   = (wrap_q > 2'd1) || (elapsed > {1'b0, gap_limit_q});
	assign short_hit = (elapsed > {1'b0, short_low_q}) && (elapsed < {1'b0, short_high_q});
	// a half period wins if both windows overlap
	assign long_hit  = !short_hit && (elapsed > {1'b0, long_low_q})
		&& (elapsed <= {1'b0, long_high_q});

	assign xlat = translate(shift_d[BYTE_W-1:0]);

	always_comb begin
		last_time_d = last_time_q;
		wrap_d      = wrap_q;
		parity_d    = parity_q;
		level_d     = level_q;
		shift_d     = shift_q;
		total_d     = total_q;
		rising_d    = rising_q;
		status_d    = ST_NONE;

		if (s_axis_tuser == OP_WRAP) begin
			// saturate the wrap count; two wraps means the frame is stale
			if (wrap_q != WRAP_MAX)
				wrap_d = wrap_q + 2'd1;
			if (wrap_d > 2'd1) begin
				parity_d = 1'b0;
				level_d  = 1'b0;
				shift_d  = '0;
				total_d  = '0;
			end
		end else begin
			last_time_d = s_axis_tdata;
			wrap_d      = 2'd0;
			if (gap_hit) begin
				// idle line: restart and rearm for the falling edge
				parity_d = 1'b0;
				level_d  = 1'b0;
				shift_d  = '0;
				total_d  = '0;
				rising_d = 1'b0;
			end else begin
				rising_d = !rising_q;
				if (!short_hit && !long_hit) begin
					status_d = ST_FAULT;
					parity_d = 1'b0;
					level_d  = 1'b0;
					shift_d  = '0;
					total_d  = '0;
				end else begin
					parity_d = parity_q ^ short_hit;
					// mid-bit edge on an even half-period count: shift a bit
					if (!parity_d) begin
						level_d = level_q ^ long_hit;
						shift_d = {shift_q[SHIFT_W-2:0], level_d};
						total_d = total_q + 1'b1;
					end
					if (total_d >= TOTAL_W'(FRAME_BITS))
						status_d = ST_COMPLETE;
				end
			end
		end
	end

	// frame fields, zero unless the frame completed; next_edge_rising always set
	always_comb begin
		res_d                  = '0;
		res_d.next_edge_rising = rising_d;
		if (status_d == ST_COMPLETE) begin
			res_d.code_word  = shift_d[FRAME_BITS-1:0];
			res_d.known_key  = xlat.known;
			res_d.tx_command = xlat.command;
			if (xlat.known)
				res_d.tx_check = device_q ^ sub_device_q ^ xlat.command;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
			wrap_q      <= '0;
			parity_q    <= 1'b0;
			level_q     <= 1'b0;
			shift_q     <= '0;
			total_q     <= '0;
			rising_q    <= 1'b0;
		end else if (s_accept) begin
			last_time_q <= last_time_d;
			wrap_q      <= wrap_d;
			rising_q    <= rising_d;
			// a completed frame starts the next one from scratch
			if (status_d == ST_COMPLETE) begin
				parity_q <= 1'b0;
				level_q  <= 1'b0;
				shift_q  <= '0;
				total_q  <= '0;
			end else begin
				parity_q <= parity_d;
				level_q  <= level_d;
				shift_q  <= shift_d;
				total_q  <= total_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			out_data_q   <= res_d;
			out_status_q <= status_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q < TOTAL_W'(FRAME_BITS))
		else $error("bit count reached frame length without completing");

	a_edge_clears_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && (s_axis_tuser == OP_EDGE) |=> (wrap_q == 2'd0))
		else $error("wrap count not cleared by a capture edge");

	a_idle_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_status_q != ST_COMPLETE) |->
			(out_data_q.code_word == '0) && !out_data_q.known_key
			&& (out_data_q.tx_command == '0) && (out_data_q.tx_check == '0))
		else $error("frame fields set without a complete frame");

	a_wrap_keeps_polarity: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && (s_axis_tuser == OP_WRAP) |=>
			(rising_q == $past(rising_q)) && (m_axis_tuser == ST_NONE))
		else $error("wrap tick changed polarity or reported status");

	a_gap_rearms_falling: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && (s_axis_tuser == OP_EDGE) && gap_hit |=>
			!rising_q && (total_q == '0))
		else $error("gap restart did not rearm the falling edge");
`endif

endmodule

>>> tb/sv/rc5_edge_decoder_translator_test.sv
`timescale 1ns / 1ps

module rc5_edge_decoder_translator_test;
	import rc5edt_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int REPORT_MAX  = 10;
	localparam int HOLD_CYCLES = 300;
	localparam int KEY_COUNT   = 6;

	// an index past the register list, written once to show it is ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	// remote key bytes and the commands they map to, entry 0 in the low byte
	localparam logic [KEY_COUNT-1:0][BYTE_W-1:0] KEY_FROM =
		{8'h0c, 8'h0d, 8'h21, 8'h20, 8'h11, 8'h10};
	localparam logic [KEY_COUNT-1:0][BYTE_W-1:0] KEY_TO =
		{8'h3d, 8'h32, 8'h35, 8'h34, 8'h21, 8'h20};

	// one capture word as it travels on the input stream
	typedef struct packed {
		logic              kind;   // OP_EDGE or OP_WRAP
		logic [TIME_W-1:0] stamp;
	} capture_t;

	// one result word: status from tuser above the tdata fields
	typedef struct packed {
		logic [1:0] status;
		result_t    body;
	} decode_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [TIME_W-1:0]     s_axis_tdata  = '0;
	logic                  s_axis_tuser  = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [31:0]           m_axis_tdata;
	logic [1:0]            m_axis_tuser;

	rc5_edge_decoder_translator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Decoder settings as last written; start from the reset values.
	logic [TIME_W-1:0] gap_limit_q  = GAP_LIMIT_RST;
	logic [TIME_W-1:0] short_low_q  = SHORT_LOW_RST;
	logic [TIME_W-1:0] short_high_q = SHORT_HIGH_RST;
	logic [TIME_W-1:0] long_low_q   = LONG_LOW_RST;
	logic [TIME_W-1:0] long_high_q  = LONG_HIGH_RST;
	logic [BYTE_W-1:0] device_q     = DEVICE_RST;
	logic [BYTE_W-1:0] sub_device_q = SUB_DEVICE_RST;

	// Decoder state tracked alongside the block.
	logic [TIME_W-1:0]  prev_stamp  = '0;
	logic [1:0]         wraps_seen  = '0;
	logic               halves_odd  = 1'b0;
	logic               level       = 1'b0;
	logic [SHIFT_W-1:0] bits_in     = '0;
	int unsigned        bit_count   = 0;
	logic               rising_next = 1'b0;

	capture_t pending_words[$];     // words waiting to be offered
	decode_t  expected_results[$];  // predicted results, oldest first

	logic              steady       = 1'b0;  // suppress random idling on both sides
	logic [TIME_W-1:0] gen_stamp    = '0;    // timer value of the last edge queued
	int unsigned       words_queued = 0;
	int unsigned       words_taken  = 0;
	int unsigned       frames_seen  = 0;
	int unsigned       keys_seen    = 0;
	int unsigned       faults_seen  = 0;
	int unsigned       mismatches   = 0;
	int unsigned       cycles       = 0;

	// ------------------------------------------------------------------
	// Decoder prediction
	// ------------------------------------------------------------------

	function automatic void restart_frame();
		halves_odd = 1'b0;
		level      = 1'b0;
		bits_in    = '0;
		bit_count  = 0;
	endfunction

	// Advance the tracked state by one capture word and return its result.
	function automatic decode_t decode_capture(capture_t w);
		decode_t           r;
		logic [TIME_W-1:0] diff;
		logic [SPAN_W-1:0] span;
		logic [1:0]        wraps;
		int unsigned       halves;
		r = '0;
		if (w.kind == OP_WRAP) begin
			// count wraps, saturating; a second one kills the frame
			if (wraps_seen != WRAP_MAX)
				wraps_seen++;
			if (wraps_seen > 2'd1)
				restart_frame();
		end else begin
			wraps = wraps_seen;
			diff  = w.stamp - prev_stamp;
			if (wraps == 2'd0)
				span = {1'b0, diff};
			else
				span = 17'h10000 - {1'b0, prev_stamp} + {1'b0, w.stamp};
			prev_stamp = w.stamp;
			wraps_seen = 2'd0;
			if (wraps > 2'd1 || span > gap_limit_q) begin
				// long silence: restart and arm for a falling edge
				restart_frame();
				rising_next = 1'b0;
			end else begin
				rising_next = ~rising_next;
				if (span > short_low_q && span < short_high_q)
					halves = 1;
				else if (span > long_low_q && span <= long_high_q)
					halves = 2;
				else
					halves = 0;
				if (halves == 0) begin
					r.status = ST_FAULT;
					restart_frame();
				end else begin
					if (halves == 1)
						halves_odd = ~halves_odd;
					// a bit lands on every whole period boundary
					if (!halves_odd) begin
						if (halves == 2)
							level = ~level;
						bits_in = {bits_in[SHIFT_W-2:0], level};
						bit_count++;
					end
					if (bit_count >= FRAME_BITS) begin
						r.status         = ST_COMPLETE;
						r.body.code_word = bits_in[FRAME_BITS-1:0];
						for (int k = 0; k < KEY_COUNT; k++) begin
							if (bits_in[BYTE_W-1:0] == KEY_FROM[k]) begin
								r.body.known_key  = 1'b1;
								r.body.tx_command = KEY_TO[k];
							end
						end
						if (r.body.known_key)
							r.body.tx_check = device_q ^ sub_device_q ^ r.body.tx_command;
						restart_frame();
					end
				end
			end
		end
		r.body.next_edge_rising = rising_next;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Input side: record accepted words, drive the next one at the falling edge
	// ------------------------------------------------------------------

	logic        word_taken = 1'b0;
	int unsigned src_gap    = 0;

	always @(posedge clk) begin : take_captures
		decode_t r;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			r = decode_capture({s_axis_tuser, s_axis_tdata});
			expected_results.push_back(r);
			words_taken++;
			if (r.status == ST_COMPLETE)
				frames_seen++;
			if (r.body.known_key)
				keys_seen++;
			if (r.status == ST_FAULT)
				faults_seen++;
		end
		word_taken <= arst_n && s_axis_tvalid && s_axis_tready;
	end

	always @(negedge clk) begin : feed_captures
		logic     offer;
		capture_t w;
		// hold the current word until it is taken
		offer = s_axis_tvalid && !word_taken;
		if (!arst_n) begin
			offer = 1'b0;
		end else if (!offer) begin
			// draw a fresh gap for each new word
			if (word_taken)
				src_gap = steady ? 0 : $urandom_range(9, 0);
			if (src_gap != 0) begin
				src_gap--;
			end else if (pending_words.size() != 0) begin
				w = pending_words.pop_front();
				s_axis_tuser <= w.kind;
				s_axis_tdata <= w.stamp;
				offer = 1'b1;
			end
		end
		s_axis_tvalid <= offer;
	end

	// ------------------------------------------------------------------
	// Output side: pace tready, check every result word against the prediction
	// ------------------------------------------------------------------

	logic        result_taken = 1'b0;
	int unsigned sink_gap     = 0;
	int unsigned hold_asked   = 0;
	int unsigned hold_done    = 0;
	int unsigned hold_left    = 0;

	// Long receiver hold-off, counted here so the sender keeps offering meanwhile.
	always @(negedge clk) begin : hold_results
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_asked != hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= hold_done + 1;
		end
	end

	always @(negedge clk) begin : pace_results
		if (result_taken)
			sink_gap = steady ? 0 : $urandom_range(9, 0);
		if (sink_gap != 0) begin
			sink_gap--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= (hold_left == 0);
		end
	end

	function automatic string describe(decode_t d);
		return $sformatf("status %0d word %h key %0b cmd %h check %h rising %0b pad %0b",
			d.status, d.body.code_word, d.body.known_key, d.body.tx_command,
			d.body.tx_check, d.body.next_edge_rising, d.body.pad);
	endfunction

	function automatic void flag_result(string detail);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("[%0t] mismatch: %s", $realtime, detail);
	endfunction

	always @(posedge clk) begin : check_results
		decode_t seen;
		decode_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen = {m_axis_tuser, m_axis_tdata};
			if (expected_results.size() == 0) begin
				flag_result({"result word with nothing expected: ", describe(seen)});
			end else begin
				want = expected_results.pop_front();
				if (seen.status !== want.status
						|| seen.body.code_word !== want.body.code_word
						|| seen.body.known_key !== want.body.known_key
						|| seen.body.tx_command !== want.body.tx_command
						|| seen.body.tx_check !== want.body.tx_check
						|| seen.body.next_edge_rising !== want.body.next_edge_rising
						|| seen.body.pad !== want.body.pad)
					flag_result({"expected ", describe(want), " / actual ", describe(seen)});
			end
		end
		result_taken <= arst_n && m_axis_tvalid && m_axis_tready;
	end

	always @(posedge clk) begin : watchdog
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, expected_results.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	task automatic push_wrap();
		pending_words.push_back({OP_WRAP, TIME_W'($urandom)});
		words_queued++;
	endtask

	task automatic push_edge(input logic [TIME_W-1:0] stamp);
		pending_words.push_back({OP_EDGE, stamp});
		gen_stamp = stamp;
		words_queued++;
	endtask

	// Queue the next edge a given interval after the last one; insert the
	// timer wrap tick when the interval crosses the top of the timer.
	task automatic advance(input int unsigned span);
		int unsigned landing;
		landing = gen_stamp + span;
		if (landing > 32'hFFFF) begin
			push_wrap();
			landing -= 32'h10000;
		end
		push_edge(TIME_W'(landing));
	endtask

	function automatic int unsigned short_span();
		return $urandom_range(short_high_q - 1, short_low_q + 1);
	endfunction

	function automatic int unsigned long_span();
		return $urandom_range(long_high_q, long_low_q + 1);
	endfunction

	// Start a fresh frame: either a silence past the gap limit or two or
	// three wraps before the first edge.
	task automatic send_lead_in();
		if (gap_limit_q > 16'd60000 || $urandom_range(3, 0) == 0) begin
			repeat ($urandom_range(3, 2))
				push_wrap();
			push_edge(TIME_W'($urandom));
		end else begin
			advance(gap_limit_q + 1 + $urandom_range(2000, 0));
		end
	endtask

	// One interval of a frame; at the spoil position drop a stray interval,
	// sometimes behind a double wrap, instead of the proper one.
	task automatic frame_step(input logic full, input int spoil_at, inout int n);
		if (n == spoil_at) begin
			if ($urandom_range(1, 0) == 1) begin
				push_wrap();
				push_wrap();
			end
			advance($urandom_range(gap_limit_q + 300, 0));
		end else begin
			advance(full ? long_span() : short_span());
		end
		n++;
	endtask

	// Manchester-encode a code word, first bit first: a level change takes one
	// full period, a repeated level two half periods, now and then with a
	// full period wedged between them that the decoder must not count.
	task automatic send_frame(input logic [FRAME_BITS-1:0] code, input int spoil_at);
		logic lvl;
		int   n;
		lvl = 1'b0;
		n   = 0;
		send_lead_in();
		for (int i = FRAME_BITS - 1; i >= 0; i--) begin
			if (code[i] != lvl) begin
				frame_step(1'b1, spoil_at, n);
				lvl = code[i];
			end else begin
				frame_step(1'b0, spoil_at, n);
				if ($urandom_range(4, 0) == 0)
					frame_step(1'b1, spoil_at, n);
				frame_step(1'b0, spoil_at, n);
			end
		end
	endtask

	task automatic scatter(input int unsigned count);
		repeat (count) begin
			if ($urandom_range(2, 0) == 0)
				push_wrap();
			else
				push_edge(TIME_W'($urandom));
		end
	endtask

	// Mostly clean frames with random content, a share keyed to the table,
	// plus spoiled frames and bursts of unrelated words.
	task automatic random_traffic(input int unsigned quota);
		int unsigned           goal;
		logic [FRAME_BITS-1:0] code;
		goal = words_queued + quota;
		while (words_queued < goal) begin
			code = FRAME_BITS'($urandom);
			if ($urandom_range(9, 0) < 4)
				code[BYTE_W-1:0] = KEY_FROM[$urandom_range(KEY_COUNT - 1, 0)];
			case ($urandom_range(9, 0))
				0:       scatter($urandom_range(6, 1));
				1, 2:    send_frame(code, $urandom_range(20, 0));
				default: send_frame(code, -1);
			endcase
		end
	endtask

	// Wait until every queued word has been taken and every result is back.
	task automatic drain();
		while (words_taken != words_queued || expected_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_GAP_LIMIT:  gap_limit_q  = value;
			REG_SHORT_LOW:  short_low_q  = value;
			REG_SHORT_HIGH: short_high_q = value;
			REG_LONG_LOW:   long_low_q   = value;
			REG_LONG_HIGH:  long_high_q  = value;
			REG_DEVICE:     device_q     = value[BYTE_W-1:0];
			REG_SUB_DEVICE: sub_device_q = value[BYTE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_settings(input logic [TIME_W-1:0] gap, t_low, t_high, tt_low,
			tt_high, input logic [BYTE_W-1:0] dev, sub_dev);
		write_reg(REG_GAP_LIMIT, gap);
		write_reg(REG_SHORT_LOW, t_low);
		write_reg(REG_SHORT_HIGH, t_high);
		write_reg(REG_LONG_LOW, tt_low);
		write_reg(REG_LONG_HIGH, tt_high);
		write_reg(REG_DEVICE, {8'h00, dev});
		write_reg(REG_SUB_DEVICE, {8'h00, sub_dev});
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed words at the reset settings: window edges, wrap handling,
		// one frame whose low byte is in the table.
		push_edge(16'h0000);          // zero interval: fault, polarity flips
		push_wrap();
		push_edge(16'h0005);          // one wrap from time zero: past the gap
		advance(32'(SHORT_LOW_RST));  // on the half period low bound: fault
		advance(32'(SHORT_HIGH_RST)); // on the half period high bound: fault
		advance(SHORT_HIGH_RST - 1);  // widest half period
		advance(32'(LONG_LOW_RST));   // on the full period low bound: fault
		advance(32'(LONG_HIGH_RST));  // inclusive top, equal to the gap limit
		advance(LONG_HIGH_RST + 1);   // just past the gap: restart
		repeat (3) push_wrap();       // wrap count climbs to its ceiling
		push_edge(16'hFFFF);
		push_edge(16'hFFFF);          // zero interval again
		send_frame({5'b10101, 8'h0d}, -1);
		random_traffic(100);
		drain();

		// Narrow, fast windows; hold the result side off for a long stretch
		// so the block stalls its input.
		write_reg(REG_SPARE, CFG_DATA_W'($urandom));
		load_settings(16'd400, 16'd90, 16'd130, 16'd190, 16'd260, 8'h5a, 8'ha5);
		hold_asked++;
		random_traffic(110);
		drain();

		// All-zero and all-ones settings: nothing decodes, only faults and restarts.
		load_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00);
		scatter(25);
		drain();
		load_settings(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 8'hff, 8'hff);
		scatter(25);
		drain();

		// One-count windows with the gap equal to the full period top. Run the
		// first half without idling, then let the sender stop until all is back.
		load_settings(16'd201, 16'd100, 16'd102, 16'd200, 16'd201, 8'h01, 8'hfe);
		steady = 1'b1;
		random_traffic(60);
		drain();
		steady = 1'b0;
		random_traffic(60);
		drain();

		// Wide intervals: timer wraps inside most frames.
		load_settings(16'd60000, 16'd20000, 16'd30000, 16'd40000, 16'd60000,
			BYTE_W'($urandom), BYTE_W'($urandom));
		random_traffic(110);
		drain();

		// Back to the usual windows with a different target device.
		load_settings(GAP_LIMIT_RST, SHORT_LOW_RST, SHORT_HIGH_RST, LONG_LOW_RST,
			LONG_HIGH_RST, 8'hff, 8'h00);
		random_traffic(100);
		drain();
		repeat (20) @(negedge clk);

		$display("%0d capture words over 7 register settings: %0d frames (%0d mapped keys),",
			words_taken, frames_seen, keys_seen);
		$display("%0d timing faults, %0d mismatches", faults_seen, mismatches);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
